### src/ffcs_pkg.sv
// ----------------------------------------------------------------------------
// ffcs_pkg
// Shared types and constants for the first-fit conflict stacking block.
// ----------------------------------------------------------------------------
package ffcs_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int MAX_BOXES_DFLT = 256;
    localparam int DIM_BITS_DFLT  = 16;

    // Fixed port widths
    localparam int IN_DIM_W    = 16;
    localparam int STACK_IDX_W = 8;
    localparam int STACK_CNT_W = 9;

    // Box store access command
    typedef struct packed {
        logic rd;
        logic wr;
    } t_box_cmd;

    // Stack mark store access command
    typedef struct packed {
        logic rd;      // read mark, result checked on the registered read data
        logic wr;      // write wr_bit at the address
        logic wr_bit;
        logic init;    // restart the first-free search
    } t_mark_cmd;

endpackage

### src/ffcs_box_mem.sv
// ----------------------------------------------------------------------------
// ffcs_box_mem
// Store of placed boxes (both dimensions and stack) with the conflict test
// against the box being placed on the registered read data.
// ----------------------------------------------------------------------------
module ffcs_box_mem
    import ffcs_pkg::*;
#(
    parameter int DEPTH = MAX_BOXES_DFLT,
    parameter int DW    = DIM_BITS_DFLT,
    parameter int AW    = $clog2(MAX_BOXES_DFLT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_box_cmd      i_cmd,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_dim_a,
    input  logic [DW-1:0] i_wr_dim_b,
    input  logic [AW-1:0] i_wr_stack,
    input  logic [DW-1:0] i_qry_a,
    input  logic [DW-1:0] i_qry_b,
    output logic          o_hit,
    output logic [AW-1:0] o_hit_stack
);

    localparam int EW = 2 * DW + AW;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] r_q;
    logic          r_rvld;

    logic [DW-1:0] w_a;
    logic [DW-1:0] w_b;
    logic          w_qry_under;
    logic          w_ent_under;

    // Memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[i_wr_addr] <= {i_wr_dim_a, i_wr_dim_b, i_wr_stack};
        end
        if (i_cmd.rd) begin
            r_q <= mem[i_rd_addr];
        end
    end

    // Read data valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= i_cmd.rd;
        end
    end

    // Conflict unless one box is strictly under the other in both dimensions
    assign w_a         = r_q[EW-1 -: DW];
    assign w_b         = r_q[AW +: DW];
    assign w_qry_under = (i_qry_a < w_a) && (i_qry_b < w_b);
    assign w_ent_under = (w_a < i_qry_a) && (w_b < i_qry_b);
    assign o_hit       = r_rvld && !(w_qry_under || w_ent_under);
    assign o_hit_stack = r_q[AW-1:0];

endmodule

### src/ffcs_mark_mem.sv
// ----------------------------------------------------------------------------
// ffcs_mark_mem
// One mark bit per stack, plus the lowest-unmarked search over the
// registered read data.
// ----------------------------------------------------------------------------
module ffcs_mark_mem
    import ffcs_pkg::*;
#(
    parameter int DEPTH = MAX_BOXES_DFLT,
    parameter int AW    = $clog2(MAX_BOXES_DFLT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mark_cmd     i_cmd,
    input  logic [AW-1:0] i_addr,
    output logic          o_found,
    output logic [AW-1:0] o_sel
);

    logic          mem [DEPTH];
    logic          r_q;
    logic          r_mvld;
    logic [AW-1:0] r_maddr;
    logic          r_found;
    logic [AW-1:0] r_sel;

    // Memory: read returns the value before a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[i_addr] <= i_cmd.wr_bit;
        end
        if (i_cmd.rd) begin
            r_q <= mem[i_addr];
        end
        r_maddr <= i_addr;
    end

    // First-free tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_mvld <= i_cmd.rd;
            if (i_cmd.init) begin
                r_found <= 1'b0;
            end else if (r_mvld && !r_q && !r_found) begin
                r_found <= 1'b1;
                r_sel   <= r_maddr;
            end
        end
    end

    assign o_found = r_found || (r_mvld && !r_q);
    assign o_sel   = r_found ? r_sel : r_maddr;

endmodule

### src/first_fit_conflict_stacking_top.sv
// ----------------------------------------------------------------------------
// first_fit_conflict_stacking_top
// Places boxes into stacks by first fit over the boxes placed so far.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a beat is taken on a rising edge with start high and busy low.
//   i_first_of_set drops all stored boxes and stacks before the box is placed.
//   Output: one result beat per input beat, o_valid high for one cycle.
//   The receiver cannot stall; each result is shown exactly once.
// Sequence:
//   A placed box keeps busy high through a conflict scan, one box-store read
//   per stored box, then a search for the lowest free stack, one mark-store
//   read per open stack. Each pass ends with a turn-around in which no store
//   read is issued; then comes the write-back. o_valid is high in the cycle
//   right after the write-back, and the next box can be taken in that cycle.
//   A refused box (store full) gives its result on the cycle after accept.
// Reset:
//   Synchronous, active low. Counts go to zero, then a clearing pass zeroes
//   all MAX_BOXES stack marks; busy is high during that pass.
// ----------------------------------------------------------------------------
module first_fit_conflict_stacking_top
    import ffcs_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DFLT,
    parameter int DIM_BITS  = DIM_BITS_DFLT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_first_of_set,
    input  logic [IN_DIM_W-1:0]    i_dim_first,
    input  logic [IN_DIM_W-1:0]    i_dim_second,
    output logic                   o_valid,
    output logic [STACK_IDX_W-1:0] o_stack_index,
    output logic [STACK_CNT_W-1:0] o_stacks_in_use,
    output logic                   o_store_full
);

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int DW = (DIM_BITS < IN_DIM_W) ? DIM_BITS : IN_DIM_W;

    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BOXES);
    localparam logic [CW-1:0] IDX_LAST = CW'(MAX_BOXES - 1);

    // State codes
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_SRCH = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]             r_state,   n_state;
    logic [CW-1:0]          r_idx,     n_idx;
    logic [CW-1:0]          r_box_cnt, n_box_cnt;
    logic [CW-1:0]          r_stk_cnt, n_stk_cnt;
    logic [DW-1:0]          r_dim_a,   n_dim_a;
    logic [DW-1:0]          r_dim_b,   n_dim_b;
    logic                   r_valid,   n_valid;
    logic [STACK_IDX_W-1:0] r_out_idx, n_out_idx;
    logic [STACK_CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic                   r_out_full, n_out_full;

    t_box_cmd      w_box_cmd;
    t_mark_cmd     w_mark_cmd;
    logic [AW-1:0] w_mark_addr;
    logic          w_hit;
    logic [AW-1:0] w_hit_stack;
    logic          w_found;
    logic [AW-1:0] w_free_sel;
    logic [AW-1:0] w_stack;
    logic [CW-1:0] w_eff_box;
    logic [CW-1:0] w_eff_stk;
    logic [CW-1:0] w_new_stk;

    // Placed-box store with conflict test
    ffcs_box_mem #(
        .DEPTH (MAX_BOXES),
        .DW    (DW),
        .AW    (AW)
    ) u_box_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_box_cmd),
        .i_rd_addr   (r_idx[AW-1:0]),
        .i_wr_addr   (r_box_cnt[AW-1:0]),
        .i_wr_dim_a  (r_dim_a),
        .i_wr_dim_b  (r_dim_b),
        .i_wr_stack  (w_stack),
        .i_qry_a     (r_dim_a),
        .i_qry_b     (r_dim_b),
        .o_hit       (w_hit),
        .o_hit_stack (w_hit_stack)
    );

    // Stack marks with first-free search
    ffcs_mark_mem #(
        .DEPTH (MAX_BOXES),
        .AW    (AW)
    ) u_mark_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mark_cmd),
        .i_addr  (w_mark_addr),
        .o_found (w_found),
        .o_sel   (w_free_sel)
    );

    // Stack picked at write-back
    assign w_stack   = w_found ? w_free_sel : r_stk_cnt[AW-1:0];
    assign w_new_stk = w_found ? r_stk_cnt : r_stk_cnt + CW'(1);

    // Counts as seen by a new beat
    assign w_eff_box = i_first_of_set ? '0 : r_box_cnt;
    assign w_eff_stk = i_first_of_set ? '0 : r_stk_cnt;

    // Control
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_box_cnt  = r_box_cnt;
        n_stk_cnt  = r_stk_cnt;
        n_dim_a    = r_dim_a;
        n_dim_b    = r_dim_b;
        n_valid    = 1'b0;
        n_out_idx  = r_out_idx;
        n_out_cnt  = r_out_cnt;
        n_out_full = r_out_full;
        w_box_cmd  = '0;
        w_mark_cmd = '0;
        w_mark_addr = r_idx[AW-1:0];

        // conflicting box marks its stack
        if (w_hit) begin
            w_mark_cmd.wr     = 1'b1;
            w_mark_cmd.wr_bit = 1'b1;
            w_mark_addr       = w_hit_stack;
        end

        case (r_state)
            ST_CLR: begin
                w_mark_cmd.wr     = 1'b1;
                w_mark_cmd.wr_bit = 1'b0;
                n_idx             = r_idx + CW'(1);
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_box_cnt = w_eff_box;
                    n_stk_cnt = w_eff_stk;
                    n_dim_a   = i_dim_first[DW-1:0];
                    n_dim_b   = i_dim_second[DW-1:0];
                    n_idx     = '0;
                    if (w_eff_box == CNT_MAX) begin
                        n_valid    = 1'b1;
                        n_out_idx  = '0;
                        n_out_cnt  = STACK_CNT_W'({{STACK_CNT_W{1'b0}}, w_eff_stk});
                        n_out_full = 1'b1;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx < r_box_cnt) begin
                    w_box_cmd.rd = 1'b1;
                    n_idx        = r_idx + CW'(1);
                end else begin
                    w_mark_cmd.init = 1'b1;
                    n_idx           = '0;
                    n_state         = ST_SRCH;
                end
            end
            ST_SRCH: begin
                // read each open stack's mark and clear it behind the read
                if (r_idx < r_stk_cnt) begin
                    w_mark_cmd.rd     = 1'b1;
                    w_mark_cmd.wr     = 1'b1;
                    w_mark_cmd.wr_bit = 1'b0;
                    n_idx             = r_idx + CW'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                w_box_cmd.wr = 1'b1;
                n_box_cnt    = r_box_cnt + CW'(1);
                n_stk_cnt    = w_new_stk;
                n_valid      = 1'b1;
                n_out_idx    = STACK_IDX_W'({{STACK_IDX_W{1'b0}}, w_stack});
                n_out_cnt    = STACK_CNT_W'({{STACK_CNT_W{1'b0}}, w_new_stk});
                n_out_full   = 1'b0;
                n_idx        = '0;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_idx     <= '0;
            r_box_cnt <= '0;
            r_stk_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_box_cnt <= n_box_cnt;
            r_stk_cnt <= n_stk_cnt;
            r_valid   <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_dim_a    <= n_dim_a;
        r_dim_b    <= n_dim_b;
        r_out_idx  <= n_out_idx;
        r_out_cnt  <= n_out_cnt;
        r_out_full <= n_out_full;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_stack_index   = r_out_idx;
    assign o_stacks_in_use = r_out_cnt;
    assign o_store_full    = r_out_full;

    // Never more stacks than boxes, never more boxes than the store holds
    a_stk_le_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stk_cnt <= r_box_cnt)
        else $error("stack count exceeds box count");

    a_box_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_box_cnt <= CNT_MAX)
        else $error("box count exceeds store depth");

    // Write-back always yields a placed (not refused) result
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (o_valid && !o_store_full))
        else $error("write-back without placed result");

    // When every open stack is marked, a new stack opens
    a_new_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !w_found) |=> (r_stk_cnt == $past(r_stk_cnt) + CW'(1)))
        else $error("stack count not advanced on new stack");

    // Refusal happens only with a full store and no set restart
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_store_full) |-> (r_box_cnt == CNT_MAX && r_state == ST_IDLE))
        else $error("refusal with room in store");

endmodule
